FILE: hw/rtl/kernel_log_line_parse_filter_defines.svh
// Assertion helpers shared by the RTL of the log line parser.
`ifndef KERNEL_LOG_LINE_PARSE_FILTER_DEFINES_SVH
`define KERNEL_LOG_LINE_PARSE_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define KLPF_ASSERT_NOW(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define KLPF_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/klpf_pkg.sv
`default_nettype none

package klpf_pkg;

  // Where the parser stands within the prefixes of the current line.
  typedef enum logic [2:0] {
    PH_START,
    PH_PRI,
    PH_CHECK,
    PH_SPACE,
    PH_SECS,
    PH_FRAC,
    PH_AFTER,
    PH_BODY
  } parse_phase_t;

  typedef enum logic [1:0] {
    REG_LEVEL_FILTER,
    REG_FACILITY_FILTER,
    REG_SOURCE_MODE
  } reg_index_t;

  localparam int APB_ADDR_WIDTH = 4;

  localparam logic [1:0] SRC_KERNEL = 2'd0;
  localparam logic [1:0] SRC_USER   = 2'd1;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;

  localparam logic [9:0]  PRIORITY_MAX   = 10'd1023;
  localparam logic [31:0] SECONDS_MAX    = 32'hFFFF_FFFF;
  localparam logic [23:0] MICROS_PER_SEC = 24'd1000000;
  localparam logic [51:0] STAMP_SAT      = 52'd4294967295000000;
  localparam logic [2:0]  FRAC_DIGITS    = 3'd6;
  localparam logic [2:0]  LEVEL_DEFAULT  = 3'd6;
  localparam logic [23:0] FACILITY_BITS  = 24'hFF_FFFF;
  localparam logic [7:0]  LEVEL_RESET    = 8'hFF;

  // Weight in microseconds of the fraction digit at position n.
  function automatic logic [16:0] frac_weight(input logic [2:0] n);
    logic [16:0] w;
    case (n)
      3'd0:    w = 17'd100000;
      3'd1:    w = 17'd10000;
      3'd2:    w = 17'd1000;
      3'd3:    w = 17'd100;
      3'd4:    w = 17'd10;
      3'd5:    w = 17'd1;
      default: w = 17'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/klpf_stream_if.sv
`default_nettype none

interface klpf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface klpf_line_if #(
  parameter int POSITION_WIDTH = 16
);
  logic                      valid;
  logic                      ready;
  logic                      line_passes;
  logic                      has_priority;
  logic [6:0]                facility_code;
  logic [2:0]                level_code;
  logic                      has_stamp;
  logic [51:0]               stamp_micros;
  logic [63:0]               delta_micros;
  logic [POSITION_WIDTH-1:0] message_offset;
  logic [POSITION_WIDTH-1:0] line_length;

  modport source (
    output valid, output line_passes, output has_priority, output facility_code,
    output level_code, output has_stamp, output stamp_micros, output delta_micros,
    output message_offset, output line_length, input ready
  );
  modport sink (
    input valid, input line_passes, input has_priority, input facility_code,
    input level_code, input has_stamp, input stamp_micros, input delta_micros,
    input message_offset, input line_length, output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/kernel_log_line_parse_filter.sv
// Log line parser and filter.
// The bytes channel takes one byte of a log buffer per transaction; a newline
// byte or a set end_of_buffer flag closes the open line. Each non-empty line
// yields one transaction on the lines channel with its priority, timestamp in
// microseconds, delta to the last passing timestamp, message offset, length
// and the verdict of the level, facility and kernel/user filters.
// Throughput is one byte per cycle while bytes.ready is high: every byte goes
// through a single pass of prefix decoding and constant-multiply accumulation
// between the parser registers. A result is registered in the output register
// when the byte ending its line is accepted, or in skid while the output is full.
// The result side has an output register plus one skid register, so bytes
// keep flowing while one result waits; bytes.ready drops only once both hold
// results, and rises again the cycle after the receiver takes one.
// Reset (synchronous, active high) clears the parser, the timestamp reference
// and both result registers, and loads the filters with their defaults. Users
// must write the filters over APB only while idle; the block does not check.
`default_nettype none

`include "kernel_log_line_parse_filter_defines.svh"

module kernel_log_line_parse_filter
  import klpf_pkg::*;
#(
  parameter int POSITION_WIDTH = 16,
  parameter int FACILITY_COUNT = 24
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  klpf_byte_if.sink                      bytes,
  klpf_line_if.source                    lines,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [APB_ADDR_WIDTH-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam logic [6:0] FAC_LIMIT = 7'(FACILITY_COUNT);

  typedef struct packed {
    logic                      line_passes;
    logic                      has_priority;
    logic [6:0]                facility_code;
    logic [2:0]                level_code;
    logic                      has_stamp;
    logic [51:0]               stamp_micros;
    logic [63:0]               delta_micros;
    logic [POSITION_WIDTH-1:0] message_offset;
    logic [POSITION_WIDTH-1:0] line_length;
  } result_t;

  // Configuration registers
  logic [7:0]                level_filter;
  logic [FACILITY_COUNT-1:0] facility_filter;
  logic [1:0]                source_mode;

  // Parser state
  parse_phase_t              phase, phase_next, phase_eff;
  logic [9:0]                priority_accum, priority_accum_next;
  logic [31:0]               seconds_accum, seconds_accum_next;
  logic [2:0]                fraction_digits, fraction_digits_next;
  logic [51:0]               stamp_value, stamp_value_next;
  logic [POSITION_WIDTH-1:0] line_position;
  logic [POSITION_WIDTH-1:0] message_start, message_start_next;
  logic                      priority_seen, priority_seen_next;
  logic                      stamp_seen, stamp_seen_next;
  logic [51:0]               previous_stamp;

  // Result registers
  logic    out_valid, skid_valid;
  result_t out_data, skid_data, result;

  logic                      accept, pop, push, line_end, is_newline, is_digit;
  logic [7:0]                c;
  logic [3:0]                digit;
  logic [POSITION_WIDTH-1:0] pos_inc, pos_after_space;
  logic [13:0]               priority_wide;
  logic [35:0]               seconds_wide;
  logic [55:0]               stamp_wide;
  logic [19:0]               frac_term;
  logic                      cfg_write;

  logic                      fin_prio_seen, fin_stamp_seen, fin_body, pass;
  logic [POSITION_WIDTH-1:0] fin_len, fin_msg;
  logic [6:0]                fin_fac;
  logic [2:0]                fin_lev;
  logic [FACILITY_COUNT-1:0] fac_bits;

  assign c          = bytes.data_byte;
  assign is_newline = (c == CH_NEWLINE);
  assign is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
  assign digit      = is_digit ? c[3:0] : 4'd0;
  assign line_end   = is_newline || bytes.end_of_buffer;

  assign bytes.ready = !skid_valid;
  assign accept      = bytes.valid && bytes.ready;
  assign pop         = out_valid && lines.ready;

  assign pos_inc         = (&line_position) ? line_position : line_position + 1'b1;
  assign pos_after_space = (c == CH_SPACE) ? pos_inc : line_position;

  // Multiply-by-ten accumulators are shift-and-add on narrow values.
  assign priority_wide = ({4'd0, priority_accum} << 3) + ({4'd0, priority_accum} << 1)
                         + 14'(digit);
  assign seconds_wide  = ({4'd0, seconds_accum} << 3) + ({4'd0, seconds_accum} << 1)
                         + 36'(digit);
  assign stamp_wide    = ({4'd0, stamp_value} << 3) + ({4'd0, stamp_value} << 1)
                         + 56'(24'(digit) * MICROS_PER_SEC);
  assign frac_term     = 20'(digit) * 20'(frac_weight(fraction_digits));

  // A byte that does not continue the current prefix falls through to the
  // next check, exactly as the fall-through in the parse order.
  always_comb begin
    phase_eff = phase;
    if (phase == PH_START && c != CH_LT) begin
      phase_eff = PH_CHECK;
    end else if (phase == PH_PRI && !is_digit && c != CH_GT) begin
      phase_eff = PH_CHECK;
    end else if (phase == PH_SPACE && c != CH_SPACE) begin
      phase_eff = PH_SECS;
    end
  end

  always_comb begin
    phase_next = phase;
    unique case (phase_eff)
      PH_START: phase_next = PH_PRI;
      PH_PRI:   phase_next = is_digit ? PH_PRI : PH_CHECK;
      PH_CHECK: phase_next = (c == CH_LBRACK) ? PH_SPACE : PH_BODY;
      PH_SPACE: phase_next = PH_SPACE;
      PH_SECS: begin
        if (is_digit) begin
          phase_next = PH_SECS;
        end else if (c == CH_DOT) begin
          phase_next = PH_FRAC;
        end else if (c == CH_RBRACK) begin
          phase_next = PH_AFTER;
        end else begin
          phase_next = PH_BODY;
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          phase_next = PH_FRAC;
        end else if (c == CH_RBRACK) begin
          phase_next = PH_AFTER;
        end else begin
          phase_next = PH_BODY;
        end
      end
      PH_AFTER: phase_next = PH_BODY;
      PH_BODY:  phase_next = PH_BODY;
      default:  phase_next = PH_BODY;
    endcase
  end

  always_comb begin
    priority_accum_next  = priority_accum;
    priority_seen_next   = priority_seen;
    seconds_accum_next   = seconds_accum;
    fraction_digits_next = fraction_digits;
    stamp_value_next     = stamp_value;
    stamp_seen_next      = stamp_seen;
    message_start_next   = message_start;
    unique case (phase_eff)
      PH_PRI: begin
        if (is_digit) begin
          priority_accum_next = (priority_wide > 14'(PRIORITY_MAX)) ? PRIORITY_MAX
                                                                    : priority_wide[9:0];
        end else begin
          priority_seen_next = 1'b1;
        end
      end
      PH_CHECK: begin
        if (c != CH_LBRACK) begin
          message_start_next = line_position;
        end
      end
      PH_SECS: begin
        // The stamp register tracks seconds times one million while the
        // seconds digits arrive, so no wide multiply is needed at the end.
        if (is_digit) begin
          if (seconds_wide > 36'(SECONDS_MAX)) begin
            seconds_accum_next = SECONDS_MAX;
            stamp_value_next   = STAMP_SAT;
          end else begin
            seconds_accum_next = seconds_wide[31:0];
            stamp_value_next   = stamp_wide[51:0];
          end
        end else if (c == CH_RBRACK) begin
          stamp_seen_next = 1'b1;
        end else if (c != CH_DOT) begin
          message_start_next = pos_after_space;
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          if (fraction_digits < FRAC_DIGITS) begin
            stamp_value_next     = stamp_value + 52'(frac_term);
            fraction_digits_next = fraction_digits + 3'd1;
          end
        end else if (c == CH_RBRACK) begin
          stamp_seen_next = 1'b1;
        end else begin
          message_start_next = pos_after_space;
        end
      end
      PH_AFTER: message_start_next = pos_after_space;
      default: ;
    endcase
  end

  // Line close. A newline is not fed to the parser; a last byte is fed first.
  // Priority and stamp values never change on the byte that marks them seen.
  always_comb begin
    fin_len        = is_newline ? line_position : pos_inc;
    fin_body       = is_newline ? (phase == PH_BODY) : (phase_next == PH_BODY);
    fin_msg        = is_newline ? message_start : message_start_next;
    fin_prio_seen  = is_newline ? priority_seen : priority_seen_next;
    fin_stamp_seen = is_newline ? stamp_seen : stamp_seen_next;
    fin_fac        = fin_prio_seen ? priority_accum[9:3] : 7'd0;
    fin_lev        = fin_prio_seen ? priority_accum[2:0] : LEVEL_DEFAULT;
    fac_bits       = facility_filter >> fin_fac;

    pass = 1'b1;
    if (facility_filter != '0) begin
      if (fin_fac >= FAC_LIMIT || !fac_bits[0]) begin
        pass = 1'b0;
      end
    end
    if (fin_prio_seen) begin
      if (source_mode != SRC_USER && fin_fac != 7'd0) begin
        pass = 1'b0;
      end
      if (source_mode != SRC_KERNEL && fin_fac == 7'd0) begin
        pass = 1'b0;
      end
      if (!level_filter[fin_lev]) begin
        pass = 1'b0;
      end
    end

    result.line_passes    = pass;
    result.has_priority   = fin_prio_seen;
    result.facility_code  = fin_fac;
    result.level_code     = fin_lev;
    result.has_stamp      = fin_stamp_seen;
    result.stamp_micros   = fin_stamp_seen ? stamp_value : 52'd0;
    result.delta_micros   = fin_stamp_seen ? ({12'd0, stamp_value} - {12'd0, previous_stamp})
                                           : 64'd0;
    result.message_offset = fin_body ? fin_msg : fin_len;
    result.line_length    = fin_len;
  end

  assign push = accept && line_end && (fin_len != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_START;
      priority_accum  <= '0;
      seconds_accum   <= '0;
      fraction_digits <= '0;
      stamp_value     <= '0;
      line_position   <= '0;
      message_start   <= '0;
      priority_seen   <= 1'b0;
      stamp_seen      <= 1'b0;
      previous_stamp  <= '0;
    end else begin
      if (accept) begin
        if (line_end) begin
          phase           <= PH_START;
          priority_accum  <= '0;
          seconds_accum   <= '0;
          fraction_digits <= '0;
          stamp_value     <= '0;
          line_position   <= '0;
          message_start   <= '0;
          priority_seen   <= 1'b0;
          stamp_seen      <= 1'b0;
        end else begin
          phase           <= phase_next;
          priority_accum  <= priority_accum_next;
          seconds_accum   <= seconds_accum_next;
          fraction_digits <= fraction_digits_next;
          stamp_value     <= stamp_value_next;
          line_position   <= pos_inc;
          message_start   <= message_start_next;
          priority_seen   <= priority_seen_next;
          stamp_seen      <= stamp_seen_next;
        end
      end
      if (push && pass && fin_stamp_seen) begin
        previous_stamp <= stamp_value;
      end
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (push) begin
      skid_data <= result;
    end
  end

  assign lines.valid          = out_valid;
  assign lines.line_passes    = out_data.line_passes;
  assign lines.has_priority   = out_data.has_priority;
  assign lines.facility_code  = out_data.facility_code;
  assign lines.level_code     = out_data.level_code;
  assign lines.has_stamp      = out_data.has_stamp;
  assign lines.stamp_micros   = out_data.stamp_micros;
  assign lines.delta_micros   = out_data.delta_micros;
  assign lines.message_offset = out_data.message_offset;
  assign lines.line_length    = out_data.line_length;

  // APB register file
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_filter    <= LEVEL_RESET;
      facility_filter <= '0;
      source_mode     <= SRC_KERNEL;
    end else if (cfg_write) begin
      unique case (reg_index_t'(paddr[3:2]))
        REG_LEVEL_FILTER:    level_filter    <= pwdata[7:0];
        REG_FACILITY_FILTER: facility_filter <= FACILITY_COUNT'(pwdata & 32'(FACILITY_BITS));
        REG_SOURCE_MODE:     source_mode     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index_t'(paddr[3:2]))
      REG_LEVEL_FILTER:    prdata = 32'(level_filter);
      REG_FACILITY_FILTER: prdata = 32'(facility_filter);
      REG_SOURCE_MODE:     prdata = 32'(source_mode);
      default:             prdata = 32'd0;
    endcase
  end

  `KLPF_ASSERT_NOW(a_skid_behind_output, clk, rst, skid_valid, out_valid,
                   "skid entry without output entry")
  `KLPF_ASSERT_NOW(a_offset_in_line, clk, rst, out_valid,
                   out_data.message_offset <= out_data.line_length,
                   "message offset beyond line length")
  `KLPF_ASSERT_NOW(a_no_empty_line, clk, rst, out_valid, out_data.line_length != '0,
                   "result for an empty line")
  `KLPF_ASSERT_NEXT(a_line_cleared, clk, rst, accept && line_end,
                    (phase == PH_START) && (line_position == '0),
                    "parser not cleared after line end")

endmodule

`default_nettype wire

FILE: sim/log_line_checker.sv
`timescale 1ns / 100ps

module log_line_checker
  import klpf_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  klpf_byte_if                           bytes,
  klpf_line_if                           lines,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic                      pready,
  input  wire logic [APB_ADDR_WIDTH-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output int                             fail_count,
  output int                             outstanding,
  output int                             lines_checked
);

  localparam logic [15:0] POS_SAT = 16'hFFFF;
  localparam int FACILITIES = 24;

  typedef struct packed {
    logic        line_passes;
    logic        has_priority;
    logic [6:0]  facility_code;
    logic [2:0]  level_code;
    logic        has_stamp;
    logic [51:0] stamp_micros;
    logic [63:0] delta_micros;
    logic [15:0] message_offset;
    logic [15:0] line_length;
  } line_rec_t;

  // Filter registers as last written over APB.
  logic [7:0]  lvl_filter;
  logic [23:0] fac_filter;
  logic [1:0]  source_sel;

  // Parser state for the open line.
  parse_phase_t phase;
  logic [9:0]   pri_acc;
  logic [31:0]  sec_acc;
  logic [19:0]  frac_acc;
  logic [2:0]   frac_n;
  logic [15:0]  line_pos;
  logic [15:0]  msg_start;
  logic         pri_seen;
  logic         stamp_seen;
  logic [51:0]  stamp_val;
  logic [51:0]  ref_stamp;

  line_rec_t expected_lines[$];

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == POS_SAT) ? v : v + 16'd1;
  endfunction

  task automatic clear_line();
    phase = PH_START;
    pri_acc = '0;
    sec_acc = '0;
    frac_acc = '0;
    frac_n = '0;
    line_pos = '0;
    msg_start = '0;
    pri_seen = 1'b0;
    stamp_seen = 1'b0;
    stamp_val = '0;
  endtask

  task automatic absorb_byte(input logic [7:0] c, input logic [15:0] at);
    logic        is_digit;
    logic [3:0]  d;
    logic [63:0] wide;
    logic [19:0] frac;
    logic [2:0]  n;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d = is_digit ? c[3:0] : 4'd0;

    if (phase == PH_START) begin
      if (c == CH_LT) begin
        phase = PH_PRI;
        return;
      end
      phase = PH_CHECK;
    end else if (phase == PH_PRI) begin
      if (is_digit) begin
        wide = 64'(pri_acc) * 64'd10 + 64'(d);
        pri_acc = (wide > 64'(PRIORITY_MAX)) ? PRIORITY_MAX : wide[9:0];
        return;
      end
      if (c == CH_GT) begin
        pri_seen = 1'b1;
        phase = PH_CHECK;
        return;
      end
      // A broken priority hands its byte on to the stamp check.
      phase = PH_CHECK;
    end

    if (phase == PH_CHECK) begin
      if (c == CH_LBRACK) begin
        phase = PH_SPACE;
      end else begin
        msg_start = at;
        phase = PH_BODY;
      end
      return;
    end
    if (phase == PH_SPACE) begin
      if (c == CH_SPACE) return;
      phase = PH_SECS;
    end
    if (phase == PH_SECS) begin
      if (is_digit) begin
        wide = 64'(sec_acc) * 64'd10 + 64'(d);
        sec_acc = (wide > 64'(SECONDS_MAX)) ? SECONDS_MAX : wide[31:0];
        return;
      end
      if (c == CH_DOT) begin
        phase = PH_FRAC;
        return;
      end
    end else if (phase == PH_FRAC) begin
      if (is_digit) begin
        if (frac_n < FRAC_DIGITS) begin
          frac_acc = frac_acc * 20'd10 + 20'(d);
          frac_n = frac_n + 3'd1;
        end
        return;
      end
    end
    if (phase == PH_SECS || phase == PH_FRAC) begin
      if (c == CH_RBRACK) begin
        frac = frac_acc;
        n = frac_n;
        while (n < FRAC_DIGITS) begin
          frac = frac * 20'd10;
          n = n + 3'd1;
        end
        wide = 64'(sec_acc) * 64'(MICROS_PER_SEC) + 64'(frac);
        stamp_val = wide[51:0];
        stamp_seen = 1'b1;
        phase = PH_AFTER;
        return;
      end
      // An unclosed stamp still lets its last byte act as the optional space.
      msg_start = (c == CH_SPACE) ? sat_inc(at) : at;
      phase = PH_BODY;
      return;
    end
    if (phase == PH_AFTER) begin
      msg_start = (c == CH_SPACE) ? sat_inc(at) : at;
      phase = PH_BODY;
    end
  endtask

  task automatic close_line();
    line_rec_t  r;
    logic [6:0] fac;
    logic [2:0] lvl;
    logic       ok;
    if (line_pos == 16'd0) begin
      clear_line();
      return;
    end
    fac = pri_seen ? pri_acc[9:3] : 7'd0;
    lvl = pri_seen ? pri_acc[2:0] : LEVEL_DEFAULT;
    ok = 1'b1;
    if (fac_filter != 24'd0) begin
      if (fac >= FACILITIES || ((fac_filter >> fac) & 24'd1) == 24'd0) ok = 1'b0;
    end
    if (pri_seen) begin
      if (source_sel != SRC_USER && fac != 7'd0) ok = 1'b0;
      if (source_sel != SRC_KERNEL && fac == 7'd0) ok = 1'b0;
      if (!lvl_filter[lvl]) ok = 1'b0;
    end
    r.line_passes = ok;
    r.has_priority = pri_seen;
    r.facility_code = fac;
    r.level_code = lvl;
    r.has_stamp = stamp_seen;
    r.stamp_micros = stamp_seen ? stamp_val : 52'd0;
    r.delta_micros = stamp_seen ? 64'(stamp_val) - 64'(ref_stamp) : 64'd0;
    r.message_offset = (phase == PH_BODY) ? msg_start : line_pos;
    r.line_length = line_pos;
    // Only a passing stamped line moves the delta reference.
    if (ok && stamp_seen) ref_stamp = stamp_val;
    expected_lines.push_back(r);
    clear_line();
  endtask

  task automatic take_byte(input logic [7:0] c, input logic last);
    if (c == CH_NEWLINE) begin
      close_line();
      return;
    end
    absorb_byte(c, line_pos);
    line_pos = sat_inc(line_pos);
    if (last) close_line();
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  task automatic compare_line();
    line_rec_t want;
    if (expected_lines.size() == 0) begin
      $display("%0t: line result with none expected, expected nothing, actual length %0d",
               $time, lines.line_length);
      fail_count++;
      return;
    end
    want = expected_lines.pop_front();
    lines_checked++;
    check_field("line_passes", 64'(want.line_passes), 64'(lines.line_passes));
    check_field("has_priority", 64'(want.has_priority), 64'(lines.has_priority));
    check_field("facility_code", 64'(want.facility_code), 64'(lines.facility_code));
    check_field("level_code", 64'(want.level_code), 64'(lines.level_code));
    check_field("has_stamp", 64'(want.has_stamp), 64'(lines.has_stamp));
    check_field("stamp_micros", 64'(want.stamp_micros), 64'(lines.stamp_micros));
    check_field("delta_micros", want.delta_micros, lines.delta_micros);
    check_field("message_offset", 64'(want.message_offset), 64'(lines.message_offset));
    check_field("line_length", 64'(want.line_length), 64'(lines.line_length));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      lvl_filter = LEVEL_RESET;
      fac_filter = '0;
      source_sel = SRC_KERNEL;
      ref_stamp = '0;
      clear_line();
      expected_lines.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_LEVEL_FILTER:    lvl_filter = pwdata[7:0];
          REG_FACILITY_FILTER: fac_filter = pwdata[23:0] & FACILITY_BITS;
          REG_SOURCE_MODE:     source_sel = pwdata[1:0];
          default: ;
        endcase
      end
      if (lines.valid && lines.ready) compare_line();
      if (bytes.valid && bytes.ready) take_byte(bytes.data_byte, bytes.end_of_buffer);
    end
    outstanding = expected_lines.size();
  end

endmodule

FILE: sim/kernel_log_line_parse_filter_test.sv
`timescale 1ns / 100ps

module kernel_log_line_parse_filter_test;
  import klpf_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 8;
  localparam int BATCH_BYTES = 170;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  localparam logic [1:0] SRC_BOTH = 2'd2;
  localparam logic [1:0] SRC_BOTH_ALIAS = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_WIDTH-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  klpf_byte_if bytes_ch();
  klpf_line_if lines_ch();

  int fail_count;
  int outstanding;
  int lines_checked;
  int cycles = 0;
  int bytes_sent = 0;
  int settings_used = 0;
  int send_idle_pct = 0;
  int take_idle_pct = 0;
  int stall_requests = 0;
  logic [8:0] byte_plan[$];

  always #4 clk = ~clk;

  kernel_log_line_parse_filter uut (
    .clk(clk),
    .rst(rst),
    .bytes(bytes_ch),
    .lines(lines_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  log_line_checker line_checker (
    .clk(clk),
    .rst(rst),
    .bytes(bytes_ch),
    .lines(lines_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .pready(pready),
    .paddr(paddr),
    .pwdata(pwdata),
    .fail_count(fail_count),
    .outstanding(outstanding),
    .lines_checked(lines_checked)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin : taker
    int served;
    served = 0;
    lines_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_requests != served) begin
        served = stall_requests;
        lines_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      lines_ch.ready <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  task automatic push_byte(input logic [7:0] c, input logic eob);
    byte_plan.push_back({eob, c});
  endtask

  task automatic plan_text(input string s, input logic eob_last);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], eob_last && (i == s.len() - 1));
  endtask

  task automatic plan_random_line();
    int         roll;
    int         n;
    int         first;
    logic [7:0] b;
    logic [8:0] tail;
    first = byte_plan.size();
    roll = $urandom_range(99);
    if (roll < 6) begin
      // Raw noise, stray newlines and buffer ends included.
      repeat ($urandom_range(1, 12)) begin
        push_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
      end
      return;
    end
    if (roll < 10) begin
      push_byte(CH_NEWLINE, 1'($urandom_range(1)));
      return;
    end
    if ($urandom_range(99) < 70) begin
      case ($urandom_range(3))
        0:       n = $urandom_range(7);
        1:       n = $urandom_range(8, 191);
        2:       n = $urandom_range(1023);
        default: n = $urandom_range(1024, 99999);
      endcase
      plan_text($sformatf("<%0d", n), 1'b0);
      if ($urandom_range(9) != 0) push_byte(CH_GT, 1'b0);
    end
    if ($urandom_range(99) < 65) begin
      push_byte(CH_LBRACK, 1'b0);
      repeat ($urandom_range(2)) push_byte(CH_SPACE, 1'b0);
      n = ($urandom_range(3) == 0) ? $urandom_range(9, 12) : $urandom_range(6);
      repeat (n) push_byte(CH_ZERO + 8'($urandom_range(9)), 1'b0);
      if ($urandom_range(2) != 0) begin
        push_byte(CH_DOT, 1'b0);
        repeat ($urandom_range(9)) push_byte(CH_ZERO + 8'($urandom_range(9)), 1'b0);
      end
      if ($urandom_range(9) != 0) push_byte(CH_RBRACK, 1'b0);
      if ($urandom_range(1) != 0) push_byte(CH_SPACE, 1'b0);
    end
    repeat ($urandom_range(10)) begin
      if ($urandom_range(4) == 0) begin
        do b = 8'($urandom_range(255)); while (b == CH_NEWLINE);
      end else begin
        b = 8'($urandom_range(32, 126));
      end
      push_byte(b, 1'b0);
    end
    roll = $urandom_range(9);
    if (roll == 0 && byte_plan.size() > first) begin
      tail = byte_plan.pop_back();
      byte_plan.push_back({1'b1, tail[7:0]});
    end else begin
      push_byte(CH_NEWLINE, roll == 1);
    end
  endtask

  task automatic send_byte(input logic [8:0] item);
    while ($urandom_range(99) < send_idle_pct) begin
      bytes_ch.valid <= 1'b0;
      @(negedge clk);
    end
    bytes_ch.valid <= 1'b1;
    bytes_ch.data_byte <= item[7:0];
    bytes_ch.end_of_buffer <= item[8];
    @(posedge clk);
    while (!bytes_ch.ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic drain_plan();
    while (byte_plan.size() != 0) send_byte(byte_plan.pop_front());
    bytes_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (outstanding != 0);
    // A byte that closes nothing may still be in flight.
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(input int k);
    logic [31:0] lvl;
    logic [31:0] fac;
    logic [1:0]  src;
    case (k % 6)
      0: begin
        lvl = 32'(LEVEL_RESET);
        fac = 32'd0;
        src = SRC_KERNEL;
      end
      1: begin
        lvl = 32'd0;
        fac = 32'hFFFF_FFFF;
        src = SRC_BOTH;
      end
      2: begin
        lvl = $urandom;
        fac = $urandom;
        src = SRC_USER;
      end
      3: begin
        lvl = $urandom;
        fac = 32'd1;
        src = SRC_BOTH_ALIAS;
      end
      4: begin
        lvl = 32'hFFFF_FF00 | $urandom_range(255);
        fac = $urandom_range(255) << 16;
        src = SRC_BOTH;
      end
      default: begin
        lvl = $urandom;
        fac = $urandom;
        src = 2'($urandom_range(3));
      end
    endcase
    wait_idle();
    apb_write(REG_LEVEL_FILTER, lvl);
    apb_write(REG_FACILITY_FILTER, fac);
    apb_write(REG_SOURCE_MODE, {30'($urandom), src});
    // Writes past the last register must leave the filters alone.
    if (k % 6 == 1) apb_write(REG_UNMAPPED, $urandom);
    settings_used++;
  endtask

  initial begin
    int setting_idx;
    setting_idx = 0;
    bytes_ch.valid = 1'b0;
    bytes_ch.data_byte = '0;
    bytes_ch.end_of_buffer = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    apply_setting(setting_idx++);
    push_byte(CH_NEWLINE, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(CH_NEWLINE, 1'b1);
    push_byte(CH_NEWLINE, 1'b1);
    plan_text("<7>[1]a\n", 1'b0);
    plan_text("<[2.5", 1'b1);
    plan_text("[3 ", 1'b1);
    drain_plan();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 28;
          take_idle_pct <= 83;
        end
        1: begin
          send_idle_pct = 83;
          take_idle_pct <= 28;
        end
        default: begin
          send_idle_pct = 0;
          take_idle_pct <= 0;
        end
      endcase
      for (int batch = 0; batch < 4; batch++) begin
        apply_setting(setting_idx++);
        // With the receiver held off, the sender keeps pushing until the block stalls.
        if (ph == 2 && batch == 0) stall_requests <= stall_requests + 1;
        while (byte_plan.size() < BATCH_BYTES) plan_random_line();
        drain_plan();
      end
    end

    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("tb: fed %0d log bytes and compared %0d line results under %0d filter settings",
             bytes_sent, lines_checked, settings_used);
    $display("tb: run mixed sender and receiver idling and a long result hold-off");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: kernel_log_line_parse_filter.f
+incdir+hw/rtl
hw/rtl/klpf_pkg.sv
hw/rtl/klpf_stream_if.sv
hw/rtl/kernel_log_line_parse_filter.sv
sim/log_line_checker.sv
sim/kernel_log_line_parse_filter_test.sv
